// ===== sv/gcdisp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the greedy change dispenser.
package gcdisp_pkg;

	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_DISPENSE = 1'b1;

	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_LINE  = 2'd1;
	localparam logic [1:0] KIND_FINAL = 2'd2;

	// Restoring division of the 24-bit amount takes one quotient bit per step.
	localparam int DIV_STEPS = 24;

	localparam int           PADDR_W      = 3;
	localparam logic         IDX_ACTIVE   = 1'b0;
	localparam logic [4:0]   ACTIVE_RESET = 5'd9;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  entry_index;
		logic [15:0] entry_value;
		logic [15:0] entry_count;
		logic [23:0] change_amount;
	} in_t;

	typedef struct packed {
		logic [1:0]  item_kind;
		logic [3:0]  paid_index;
		logic [15:0] paid_value;
		logic [15:0] paid_count;
		logic [23:0] remainder;
		logic        last;
	} res_t;

	typedef struct packed {
		logic accept;
		logic rd;
		logic skip;
		logic div_start;
		logic div_step;
		logic take;
		logic mul;
		logic emit_ack;
		logic emit_line;
		logic emit_final;
	} cmd_t;

	typedef struct packed {
		logic is_load;
		logic walk_done;
		logic usable;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

// ===== sv/gcdisp_dp.sv =====
`timescale 1ns / 1ps
// Datapath: denomination tables, serial divider, multiplier and result register.
module gcdisp_dp #(
	parameter int MAX_DENOMS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gcdisp_pkg::cmd_t   cmd,
	output gcdisp_pkg::sts_t   sts,
	input  gcdisp_pkg::in_t    in_data,
	input  logic [4:0]         active_count,
	input  logic               out_ready,
	output logic               out_valid,
	output gcdisp_pkg::res_t   out_data
);
	import gcdisp_pkg::*;

	localparam int AW = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
	localparam int WALK_MAX = (MAX_DENOMS < 16) ? MAX_DENOMS : 16;
	localparam logic [4:0] WALK_MAX_V = 5'(WALK_MAX);

	logic [15:0] val_mem [MAX_DENOMS];
	logic [15:0] cnt_mem [MAX_DENOMS];
	logic [MAX_DENOMS-1:0] vld_q;

	in_t         in_q;
	logic [23:0] amt_q;
	logic [4:0]  idx_q;
	logic [15:0] rd_val_q;
	logic [15:0] rd_cnt_q;
	logic        rd_hit_q;
	logic [15:0] prem_q;
	logic [23:0] dq_q;
	logic [4:0]  div_cnt_q;
	logic [15:0] take_q;
	logic [31:0] prod_q;
	logic        out_valid_q;
	res_t        out_q;

	logic [15:0] cur_val;
	logic [15:0] cur_cnt;
	logic [4:0]  walk_lim;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic        load_in_range;
	logic        mem_we;
	logic [15:0] mem_wval;
	logic [15:0] mem_wcnt;
	logic [16:0] trial;
	logic [17:0] diff;
	logic        ge;
	logic [23:0] new_amt;

	// An entry never written reads as empty.
	assign cur_val = rd_hit_q ? rd_val_q : 16'd0;
	assign cur_cnt = rd_hit_q ? rd_cnt_q : 16'd0;

	assign walk_lim = (active_count < WALK_MAX_V) ? active_count : WALK_MAX_V;
	assign raddr    = AW'(idx_q);
	assign load_in_range = {28'd0, in_q.entry_index} < 32'(MAX_DENOMS);

	assign mem_we   = (cmd.emit_ack && load_in_range) || cmd.emit_line;
	assign waddr    = cmd.emit_line ? AW'(idx_q) : AW'(in_q.entry_index);
	assign mem_wval = cmd.emit_line ? cur_val : in_q.entry_value;
	assign mem_wcnt = cmd.emit_line ? (cur_cnt - take_q) : in_q.entry_count;

	// One restoring division step: during a division the partial remainder stays below the divisor.
	assign trial   = {prem_q, dq_q[23]};
	assign diff    = {1'b0, trial} - {2'b00, cur_val};
	assign ge      = ~diff[17];
	assign new_amt = amt_q - prod_q[23:0];

	assign sts.is_load   = (in_q.opcode == OP_LOAD);
	assign sts.walk_done = (idx_q >= walk_lim);
	assign sts.usable    = (cur_val != 16'd0) && (cur_cnt != 16'd0) &&
	                       (amt_q >= {8'd0, cur_val});
	assign sts.div_last  = (div_cnt_q == 5'(DIV_STEPS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			val_mem[waddr] <= mem_wval;
			cnt_mem[waddr] <= mem_wcnt;
		end
		if (cmd.rd) begin
			rd_val_q <= val_mem[raddr];
			rd_cnt_q <= cnt_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			rd_hit_q    <= 1'b0;
			idx_q       <= 5'd0;
			div_cnt_q   <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (cmd.rd) begin
				rd_hit_q <= vld_q[raddr];
			end
			if (cmd.accept) begin
				idx_q <= 5'd0;
			end else if (cmd.skip || cmd.emit_line) begin
				idx_q <= idx_q + 5'd1;
			end
			if (cmd.div_start) begin
				div_cnt_q <= 5'd0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 5'd1;
			end
			if (cmd.emit_ack || cmd.emit_line || cmd.emit_final) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_q  <= in_data;
			amt_q <= in_data.change_amount;
		end else if (cmd.emit_line) begin
			amt_q <= new_amt;
		end
		if (cmd.div_start) begin
			prem_q <= 16'd0;
			dq_q   <= amt_q;
		end else if (cmd.div_step) begin
			prem_q <= ge ? diff[15:0] : trial[15:0];
			dq_q   <= {dq_q[22:0], ge};
		end
		if (cmd.take) begin
			take_q <= (dq_q > {8'd0, cur_cnt}) ? cur_cnt : dq_q[15:0];
		end
		if (cmd.mul) begin
			prod_q <= 32'(take_q) * 32'(cur_val);
		end
		if (cmd.emit_ack) begin
			out_q.item_kind  <= KIND_ACK;
			out_q.paid_index <= in_q.entry_index;
			out_q.paid_value <= in_q.entry_value;
			out_q.paid_count <= in_q.entry_count;
			out_q.remainder  <= 24'd0;
			out_q.last       <= 1'b1;
		end else if (cmd.emit_line) begin
			out_q.item_kind  <= KIND_LINE;
			out_q.paid_index <= idx_q[3:0];
			out_q.paid_value <= cur_val;
			out_q.paid_count <= take_q;
			out_q.remainder  <= new_amt;
			out_q.last       <= 1'b0;
		end else if (cmd.emit_final) begin
			out_q.item_kind  <= KIND_FINAL;
			out_q.paid_index <= 4'd0;
			out_q.paid_value <= 16'd0;
			out_q.paid_count <= 16'd0;
			out_q.remainder  <= amt_q;
			out_q.last       <= 1'b1;
		end
	end

	a_prod_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_line |-> (prod_q <= {8'd0, amt_q}))
		else $error("payout exceeds the amount still owed");

	a_take_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_line |-> (take_q != 16'd0) && (take_q <= cur_cnt))
		else $error("paid count is zero or exceeds the stock");

	a_amt_falls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_line |=> (amt_q <= $past(amt_q)))
		else $error("remaining amount grew after a paid line");

endmodule

// ===== sv/gcdisp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine that sequences loads and the dispense walk.
module gcdisp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gcdisp_pkg::sts_t sts,
	output gcdisp_pkg::cmd_t cmd
);
	import gcdisp_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_ACK   = 4'd2;
	localparam logic [3:0] S_WALK  = 4'd3;
	localparam logic [3:0] S_CHK   = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_TAKE  = 4'd6;
	localparam logic [3:0] S_MUL   = 4'd7;
	localparam logic [3:0] S_LINE  = 4'd8;
	localparam logic [3:0] S_FINAL = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DEC;
				end
			end
			S_DEC: begin
				state_d = sts.is_load ? S_ACK : S_WALK;
			end
			S_ACK: begin
				if (sts.out_free) begin
					cmd.emit_ack = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_WALK: begin
				if (sts.walk_done) begin
					state_d = S_FINAL;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.usable) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					cmd.skip = 1'b1;
					state_d  = S_WALK;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_TAKE;
				end
			end
			S_TAKE: begin
				cmd.take = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_LINE;
			end
			S_LINE: begin
				if (sts.out_free) begin
					cmd.emit_line = 1'b1;
					state_d       = S_WALK;
				end
			end
			S_FINAL: begin
				if (sts.out_free) begin
					cmd.emit_final = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_ack, cmd.emit_line, cmd.emit_final}))
		else $error("more than one result written in a cycle");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_ack || cmd.emit_line || cmd.emit_final) |-> sts.out_free)
		else $error("result written while the output register is occupied");

	a_accept_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == S_DEC) && !in_ready)
		else $error("accepted item not decoded");

endmodule

// ===== sv/greedy_change_dispenser.sv =====
`timescale 1ns / 1ps
// Top level of the greedy change dispenser: register port, controller and datapath.
// Load item: accepted, decoded, then acknowledged once the output register is free.
// Dispense item: each entry below the walk limit is read, then skipped, or paid through
// the bit-serial divider, the take and the multiply; the walk ends with the final item,
// and an output stall holds any result. One item is worked at a time; the next is taken
// once the last result is registered. Reset clears the tables to empty and sets
// active_count to 9; there is no clearing pass.
module greedy_change_dispenser #(
	parameter int MAX_DENOMS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  gcdisp_pkg::in_t                     in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output gcdisp_pkg::res_t                    out_data,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gcdisp_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import gcdisp_pkg::*;

	// The only register, active_count, sits at byte address 0. Address bit 2
	// selects the register index; anything at index 1 reads as zero and ignores writes.
	logic [4:0] active_count_q;
	logic       cfg_wr;
	cmd_t       cmd;
	sts_t       sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == IDX_ACTIVE);
	assign prdata = (paddr[2] == IDX_ACTIVE) ? {27'd0, active_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= ACTIVE_RESET;
		end else if (cfg_wr) begin
			active_count_q <= pwdata[4:0];
		end
	end

	// The controller sequences each item; the datapath holds the tables, the
	// divider and the output register that lets a result wait for the consumer.
	gcdisp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gcdisp_dp #(
		.MAX_DENOMS (MAX_DENOMS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_data      (in_data),
		.active_count (active_count_q),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_data     (out_data)
	);

endmodule
